// ----- design/step_lobe_peak_tracker_macros.svh -----
// assertion macros shared by the step lobe peak tracker modules
`ifndef STEP_LOBE_PEAK_TRACKER_MACROS_SVH
`define STEP_LOBE_PEAK_TRACKER_MACROS_SVH

// condition holds at every clock edge out of reset
`define SLPT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SLPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/slpt_pkg.sv -----
// shared types and constants of the step lobe peak tracker
package slpt_pkg;

  // parameter defaults
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  // fixed field widths
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;
  localparam int WIN_CFG_BITS  = 7;
  localparam int GAP_BITS      = 16;
  localparam int AMP_BITS      = 16;
  localparam int SEG_OUT_BITS  = 32;
  localparam int FUNC_BITS     = 2;

  // func codes
  localparam logic [FUNC_BITS-1:0] FUNC_FEED    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_CLR_SEG = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_CLR_ALL = 2'd2;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_UP_THR   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DOWN_THR = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_GAP  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_AMP  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_WINDOW   = 3'd4;

  // register reset values
  localparam int UP_THR_RST   = 256;
  localparam int DOWN_THR_RST = -256;
  localparam int MIN_GAP_RST  = 200;
  localparam int MIN_AMP_RST  = 512;
  localparam int WINDOW_RST   = 5;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FEED  = 8'b0000_0010,
    S_DIVL  = 8'b0000_0100,
    S_LEAK  = 8'b0000_1000,
    S_LOADZ = 8'b0001_0000,
    S_DIVZ  = 8'b0010_0000,
    S_LOBE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic capture;    // latch sample and timestamp
    logic clr_seg;    // clear segment state
    logic clr_all;    // clear all state
    logic upd_fill;   // sum += x while window fills
    logic div_load;   // start a division of the sum
    logic div_sel_z;  // divisor: 1 output divisor, 0 window
    logic div_step;   // advance the divider
    logic upd_leak;   // sum += x - sum/window
    logic lobe;       // commit smoothed value and lobe tracking
    logic out_load;   // load the output word
  } cmd_t;

  typedef struct packed {
    logic fill;       // fewer samples than the window so far
    logic div_last;   // divider is on its last step
  } sts_t;

endpackage

// ----- design/slpt_div.sv -----
// serial signed divider, two quotient bits per cycle while step is high, truncates toward zero
module slpt_div #(
  parameter int NUM_BITS = 24,
  parameter int DEN_BITS = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       step,
  input  logic signed [NUM_BITS-1:0] num,
  input  logic        [DEN_BITS-1:0] den,
  output logic                       last,
  output logic signed [NUM_BITS:0]   quo
);

  localparam int DIV_BITS = NUM_BITS + (NUM_BITS % 2);
  localparam int STEPS    = DIV_BITS / 2;
  localparam int CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DIV_BITS-1:0] acc_r, acc_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [NUM_BITS:0]   qm;

  always_comb begin
    logic [DEN_BITS:0]   rem_sh;
    logic [NUM_BITS-1:0] mag;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    rem_sh  = '0;
    mag     = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    if (load) begin
      acc_nxt = DIV_BITS'(mag);
      rem_nxt = '0;
      den_nxt = den;
      neg_nxt = num[NUM_BITS-1];
      cnt_nxt = '0;
    end else if (step) begin
      for (int i = 0; i < 2; i++) begin
        rem_sh  = {rem_nxt, acc_nxt[DIV_BITS-1]};
        acc_nxt = {acc_nxt[DIV_BITS-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_r}) begin
          rem_sh     = rem_sh - {1'b0, den_r};
          acc_nxt[0] = 1'b1;
        end
        rem_nxt = rem_sh[DEN_BITS-1:0];
      end
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign last = (cnt_r == CNT_BITS'(STEPS - 1));
  assign qm   = (NUM_BITS + 1)'(acc_r);
  assign quo  = neg_r ? -$signed(qm) : $signed(qm);

endmodule

// ----- design/slpt_dp.sv -----
// datapath: moving average, lobe tracking, step check and output word
`include "step_lobe_peak_tracker_macros.svh"
module slpt_dp #(
  parameter int MAX_WINDOW  = slpt_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = slpt_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = slpt_pkg::TIME_BITS_DEF,
  parameter int THR_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  slpt_pkg::cmd_t                       cmd,
  output slpt_pkg::sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0]        accel_z,
  input  logic        [TIME_BITS-1:0]          time_ms,
  input  logic signed [THR_BITS-1:0]           up_thr,
  input  logic signed [THR_BITS-1:0]           down_thr,
  input  logic [slpt_pkg::GAP_BITS-1:0]        min_gap,
  input  logic [slpt_pkg::AMP_BITS-1:0]        min_amp,
  input  logic [slpt_pkg::WIN_CFG_BITS-1:0]    window,
  output logic signed [SAMPLE_BITS-1:0]        smoothed_z,
  output logic                                 step_valid,
  output logic                                 in_up_lobe,
  output logic                                 in_down_lobe,
  output logic [slpt_pkg::SEG_OUT_BITS-1:0]    segment_start_ms,
  output logic                                 segment_started
);

  localparam int SUM_BITS = SAMPLE_BITS + 8;
  localparam int EW       = SUM_BITS + 2;
  localparam int ZW       = SUM_BITS + 1;
  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
  localparam int CW       = (WIN_BITS > slpt_pkg::WIN_CFG_BITS) ? WIN_BITS
                                                                 : slpt_pkg::WIN_CFG_BITS;
  localparam int AW       = (SAMPLE_BITS + 2 > slpt_pkg::AMP_BITS + 2) ? SAMPLE_BITS + 2
                                                                       : slpt_pkg::AMP_BITS + 2;
  localparam int GW       = (TIME_BITS > slpt_pkg::GAP_BITS) ? TIME_BITS : slpt_pkg::GAP_BITS;
  localparam int TW       = (TIME_BITS > slpt_pkg::SEG_OUT_BITS) ? TIME_BITS
                                                                  : slpt_pkg::SEG_OUT_BITS;

  localparam longint SUM_HI_L = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO_L = -SUM_HI_L - 1;
  localparam longint Z_HI_L   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint Z_LO_L   = -Z_HI_L - 1;

  localparam logic signed [EW-1:0]          SUM_HI = EW'(SUM_HI_L);
  localparam logic signed [EW-1:0]          SUM_LO = EW'(SUM_LO_L);
  localparam logic signed [ZW-1:0]          Z_HI   = ZW'(Z_HI_L);
  localparam logic signed [ZW-1:0]          Z_LO   = ZW'(Z_LO_L);
  localparam logic signed [SAMPLE_BITS-1:0] MAX_RST = SAMPLE_BITS'(Z_LO_L);
  localparam logic signed [SAMPLE_BITS-1:0] MIN_RST = SAMPLE_BITS'(Z_HI_L);

  // captured item
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic        [TIME_BITS-1:0]   t_r;

  // average state
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic        [WIN_BITS-1:0]    cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] last_r, last_nxt;

  // segment state
  logic                          up_lobe_r, up_lobe_nxt;
  logic                          down_lobe_r, down_lobe_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic        [TIME_BITS-1:0]   up_time_r, up_time_nxt;
  logic        [TIME_BITS-1:0]   down_time_r, down_time_nxt;
  logic        [TIME_BITS-1:0]   start_time_r, start_time_nxt;
  logic                          up_seen_r, up_seen_nxt;
  logic                          down_seen_r, down_seen_nxt;
  logic                          start_seen_r, start_seen_nxt;

  // output word
  logic signed [SAMPLE_BITS-1:0]         smoothed_r;
  logic                                  step_r;
  logic                                  out_up_r;
  logic                                  out_down_r;
  logic [slpt_pkg::SEG_OUT_BITS-1:0]     seg_start_r;
  logic                                  seg_started_r;

  // window and divisor
  logic [CW-1:0]       win_c, weff_c, cnt_c, d_c;
  logic [WIN_BITS-1:0] den;
  logic                div_last;
  logic signed [ZW-1:0] quo;
  logic signed [SAMPLE_BITS-1:0] z;

  // step check
  logic signed [AW-1:0] amp_diff, amp_min;
  logic [TIME_BITS-1:0] gap_t;
  logic                 order_ok, amp_ok, gap_ok, step_ok;
  logic [TW-1:0]        start_ext;

  always_comb begin
    win_c = CW'(window);
    if (win_c == '0) begin
      weff_c = CW'(1);
    end else if (win_c > CW'(MAX_WINDOW)) begin
      weff_c = CW'(MAX_WINDOW);
    end else begin
      weff_c = win_c;
    end
    cnt_c = CW'(cnt_r);
    d_c   = (cnt_c < weff_c) ? cnt_c : weff_c;
    if (d_c == '0) begin
      d_c = CW'(1);
    end
    den = cmd.div_sel_z ? WIN_BITS'(d_c) : WIN_BITS'(weff_c);
  end

  assign sts.fill     = (cnt_c < weff_c);
  assign sts.div_last = div_last;

  slpt_div #(
    .NUM_BITS (SUM_BITS),
    .DEN_BITS (WIN_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.div_load),
    .step  (cmd.div_step),
    .num   (sum_r),
    .den   (den),
    .last  (div_last),
    .quo   (quo)
  );

  // saturated smoothed value
  always_comb begin
    if (quo > Z_HI) begin
      z = SAMPLE_BITS'(Z_HI);
    end else if (quo < Z_LO) begin
      z = SAMPLE_BITS'(Z_LO);
    end else begin
      z = SAMPLE_BITS'(quo);
    end
  end

  always_comb begin
    logic signed [EW-1:0] s;
    s              = '0;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    up_lobe_nxt    = up_lobe_r;
    down_lobe_nxt  = down_lobe_r;
    max_nxt        = max_r;
    min_nxt        = min_r;
    up_time_nxt    = up_time_r;
    down_time_nxt  = down_time_r;
    start_time_nxt = start_time_r;
    up_seen_nxt    = up_seen_r;
    down_seen_nxt  = down_seen_r;
    start_seen_nxt = start_seen_r;

    if (cmd.upd_fill || cmd.upd_leak) begin
      s = EW'(sum_r) + EW'(x_r);
      if (cmd.upd_leak) begin
        s = s - EW'(quo);
      end
      if (s > SUM_HI) begin
        sum_nxt = SUM_BITS'(SUM_HI);
      end else if (s < SUM_LO) begin
        sum_nxt = SUM_BITS'(SUM_LO);
      end else begin
        sum_nxt = SUM_BITS'(s);
      end
      if (cmd.upd_fill) begin
        cnt_nxt = cnt_r + WIN_BITS'(1);
      end
    end

    if (cmd.lobe) begin
      last_nxt = z;
      // upward crossing first, then downward
      if (!up_lobe_nxt && (z > up_thr)) begin
        up_lobe_nxt   = 1'b1;
        down_lobe_nxt = 1'b0;
        if (z > max_nxt) begin
          max_nxt = z;
        end
        up_time_nxt = t_r;
        up_seen_nxt = 1'b1;
        if (!start_seen_nxt) begin
          start_time_nxt = t_r;
          start_seen_nxt = 1'b1;
        end
      end else if (up_lobe_nxt) begin
        if (z > max_nxt) begin
          max_nxt = z;
        end
      end
      if (!down_lobe_nxt && (z < down_thr)) begin
        down_lobe_nxt = 1'b1;
        up_lobe_nxt   = 1'b0;
        if (z < min_nxt) begin
          min_nxt = z;
        end
        down_time_nxt = t_r;
        down_seen_nxt = 1'b1;
      end else if (down_lobe_nxt) begin
        if (z < min_nxt) begin
          min_nxt = z;
        end
      end
    end

    if (cmd.clr_seg || cmd.clr_all) begin
      up_lobe_nxt    = 1'b0;
      down_lobe_nxt  = 1'b0;
      max_nxt        = MAX_RST;
      min_nxt        = MIN_RST;
      up_time_nxt    = '0;
      down_time_nxt  = '0;
      start_time_nxt = '0;
      up_seen_nxt    = 1'b0;
      down_seen_nxt  = 1'b0;
      start_seen_nxt = 1'b0;
    end
    if (cmd.clr_all) begin
      sum_nxt  = '0;
      cnt_nxt  = '0;
      last_nxt = '0;
    end
  end

  // step check over the current state
  always_comb begin
    amp_diff = AW'(max_r) - AW'(min_r);
    amp_min  = $signed(AW'(min_amp));
    gap_t    = down_time_r - up_time_r;
    order_ok = (down_time_r >= up_time_r);
    amp_ok   = (amp_diff >= amp_min);
    gap_ok   = order_ok && (GW'(gap_t) >= GW'(min_gap));
    step_ok  = up_seen_r && down_seen_r && order_ok && amp_ok && gap_ok;
  end

  assign start_ext = TW'(start_time_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      cnt_r        <= '0;
      last_r       <= '0;
      up_lobe_r    <= 1'b0;
      down_lobe_r  <= 1'b0;
      max_r        <= MAX_RST;
      min_r        <= MIN_RST;
      up_time_r    <= '0;
      down_time_r  <= '0;
      start_time_r <= '0;
      up_seen_r    <= 1'b0;
      down_seen_r  <= 1'b0;
      start_seen_r <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      last_r       <= last_nxt;
      up_lobe_r    <= up_lobe_nxt;
      down_lobe_r  <= down_lobe_nxt;
      max_r        <= max_nxt;
      min_r        <= min_nxt;
      up_time_r    <= up_time_nxt;
      down_time_r  <= down_time_nxt;
      start_time_r <= start_time_nxt;
      up_seen_r    <= up_seen_nxt;
      down_seen_r  <= down_seen_nxt;
      start_seen_r <= start_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= accel_z;
      t_r <= time_ms;
    end
    if (cmd.out_load) begin
      smoothed_r    <= last_r;
      step_r        <= step_ok;
      out_up_r      <= up_lobe_r;
      out_down_r    <= down_lobe_r;
      seg_start_r   <= start_seen_r ? start_ext[slpt_pkg::SEG_OUT_BITS-1:0] : '0;
      seg_started_r <= start_seen_r;
    end
  end

  assign smoothed_z       = smoothed_r;
  assign step_valid       = step_r;
  assign in_up_lobe       = out_up_r;
  assign in_down_lobe     = out_down_r;
  assign segment_start_ms = seg_start_r;
  assign segment_started  = seg_started_r;

  `SLPT_ASSERT_ALWAYS(a_lobe_excl, clk, rst_n, !(up_lobe_r && down_lobe_r), "both lobe flags set")
  `SLPT_ASSERT_IMPLY(a_den_nz, clk, rst_n, cmd.div_load, den != '0, "divider loaded with zero")

endmodule

// ----- design/slpt_ctrl.sv -----
// controller: sequences one item through the datapath and owns both handshakes
`include "step_lobe_peak_tracker_macros.svh"
module slpt_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [slpt_pkg::FUNC_BITS-1:0]     in_func,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  output slpt_pkg::cmd_t                     cmd,
  input  slpt_pkg::sts_t                     sts
);

  slpt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      slpt_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_func)
            slpt_pkg::FUNC_FEED: begin
              state_nxt = slpt_pkg::S_FEED;
            end
            slpt_pkg::FUNC_CLR_SEG: begin
              cmd.clr_seg = 1'b1;
              state_nxt   = slpt_pkg::S_OUT;
            end
            slpt_pkg::FUNC_CLR_ALL: begin
              cmd.clr_all = 1'b1;
              state_nxt   = slpt_pkg::S_OUT;
            end
            default: begin
              state_nxt = slpt_pkg::S_OUT;
            end
          endcase
        end
      end
      slpt_pkg::S_FEED: begin
        if (sts.fill) begin
          cmd.upd_fill = 1'b1;
          state_nxt    = slpt_pkg::S_LOADZ;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt    = slpt_pkg::S_DIVL;
        end
      end
      slpt_pkg::S_DIVL: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = slpt_pkg::S_LEAK;
        end
      end
      slpt_pkg::S_LEAK: begin
        cmd.upd_leak = 1'b1;
        state_nxt    = slpt_pkg::S_LOADZ;
      end
      slpt_pkg::S_LOADZ: begin
        cmd.div_load  = 1'b1;
        cmd.div_sel_z = 1'b1;
        state_nxt     = slpt_pkg::S_DIVZ;
      end
      slpt_pkg::S_DIVZ: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = slpt_pkg::S_LOBE;
        end
      end
      slpt_pkg::S_LOBE: begin
        cmd.lobe  = 1'b1;
        state_nxt = slpt_pkg::S_OUT;
      end
      slpt_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = slpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = slpt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slpt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != slpt_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  `SLPT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted a word without going busy")
  `SLPT_ASSERT_NEXT(a_out_after_load, clk, rst_n, cmd.out_load, out_valid, "output word loaded but not valid")
  `SLPT_ASSERT_NEXT(a_divz_to_lobe, clk, rst_n, (state_r == slpt_pkg::S_DIVZ) && sts.div_last, state_r == slpt_pkg::S_LOBE, "output division did not end in lobe update")
  `SLPT_ASSERT_ALWAYS(a_cmd_excl, clk, rst_n, $onehot0({cmd.clr_seg, cmd.clr_all, cmd.upd_fill, cmd.div_load, cmd.div_step, cmd.upd_leak, cmd.lobe, cmd.out_load}), "conflicting datapath commands")

endmodule

// ----- design/step_lobe_peak_tracker.sv -----
// step lobe peak tracker top level: register port, controller and datapath
// Usage:
//   input channel  in_valid / in_stall carries one word: in_func, in_accel_z
//   (signed Q7.8) and in_time_ms. func feed smooths a sample and tracks lobes,
//   clear segment and clear all reset that part of the state; any other code
//   leaves the state alone. Each accepted word yields exactly one result word.
//   result channel out_valid / out_stall carries smoothed value, step flag,
//   lobe flags and segment start.
//   timing: a feed word runs a shared serial divider at two quotient bits per
//   cycle. while the window fills one division is needed; once the window is
//   full the leak term needs a second division. clear words skip the divider.
//   a new word is taken the cycle after the previous result is loaded into
//   the output register.
//   stall: the output register holds one finished word; the next item can be
//   accepted and worked on while it waits, and that item then waits in the
//   last controller state until the register frees up.
//   reset (rst_n low, synchronous): all tracking state cleared, registers back
//   to defaults, output invalid. no clearing pass is needed.
//   registers via APB: write takes setup and access cycles, pready tied high.
module step_lobe_peak_tracker #(
  parameter int MAX_WINDOW  = slpt_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = slpt_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = slpt_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [slpt_pkg::FUNC_BITS-1:0]       in_func,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_z,
  input  logic [TIME_BITS-1:0]                 in_time_ms,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_smoothed_z,
  output logic                                 out_step_valid,
  output logic                                 out_in_up_lobe,
  output logic                                 out_in_down_lobe,
  output logic [slpt_pkg::SEG_OUT_BITS-1:0]    out_segment_start_ms,
  output logic                                 out_segment_started,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [slpt_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [slpt_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [slpt_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  // thresholds keep at least enough bits for their reset values
  localparam int THR_BITS = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;

  logic signed [THR_BITS-1:0]              up_thr_r, up_thr_nxt;
  logic signed [THR_BITS-1:0]              down_thr_r, down_thr_nxt;
  logic [slpt_pkg::GAP_BITS-1:0]           min_gap_r, min_gap_nxt;
  logic [slpt_pkg::AMP_BITS-1:0]           min_amp_r, min_amp_nxt;
  logic [slpt_pkg::WIN_CFG_BITS-1:0]       window_r, window_nxt;

  logic                                    cfg_wr;
  logic [slpt_pkg::REG_IDX_BITS-1:0]       reg_idx;
  logic signed [THR_BITS-1:0]              thr_wdata;

  slpt_pkg::cmd_t cmd;
  slpt_pkg::sts_t sts;

  // register file
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[slpt_pkg::CFG_ADDR_BITS-1:2];
  // thresholds are sign extended from the sample width
  assign thr_wdata = THR_BITS'($signed(pwdata[SAMPLE_BITS-1:0]));

  always_comb begin
    up_thr_nxt   = up_thr_r;
    down_thr_nxt = down_thr_r;
    min_gap_nxt  = min_gap_r;
    min_amp_nxt  = min_amp_r;
    window_nxt   = window_r;
    if (cfg_wr) begin
      case (reg_idx)
        slpt_pkg::REG_UP_THR:   up_thr_nxt   = thr_wdata;
        slpt_pkg::REG_DOWN_THR: down_thr_nxt = thr_wdata;
        slpt_pkg::REG_MIN_GAP:  min_gap_nxt  = pwdata[slpt_pkg::GAP_BITS-1:0];
        slpt_pkg::REG_MIN_AMP:  min_amp_nxt  = pwdata[slpt_pkg::AMP_BITS-1:0];
        slpt_pkg::REG_WINDOW:   window_nxt   = pwdata[slpt_pkg::WIN_CFG_BITS-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_thr_r   <= THR_BITS'(slpt_pkg::UP_THR_RST);
      down_thr_r <= THR_BITS'(slpt_pkg::DOWN_THR_RST);
      min_gap_r  <= slpt_pkg::GAP_BITS'(slpt_pkg::MIN_GAP_RST);
      min_amp_r  <= slpt_pkg::AMP_BITS'(slpt_pkg::MIN_AMP_RST);
      window_r   <= slpt_pkg::WIN_CFG_BITS'(slpt_pkg::WINDOW_RST);
    end else begin
      up_thr_r   <= up_thr_nxt;
      down_thr_r <= down_thr_nxt;
      min_gap_r  <= min_gap_nxt;
      min_amp_r  <= min_amp_nxt;
      window_r   <= window_nxt;
    end
  end

  // read back, thresholds sign extended
  always_comb begin
    case (reg_idx)
      slpt_pkg::REG_UP_THR:   prdata = slpt_pkg::CFG_DATA_BITS'(up_thr_r);
      slpt_pkg::REG_DOWN_THR: prdata = slpt_pkg::CFG_DATA_BITS'(down_thr_r);
      slpt_pkg::REG_MIN_GAP:  prdata = slpt_pkg::CFG_DATA_BITS'(min_gap_r);
      slpt_pkg::REG_MIN_AMP:  prdata = slpt_pkg::CFG_DATA_BITS'(min_amp_r);
      slpt_pkg::REG_WINDOW:   prdata = slpt_pkg::CFG_DATA_BITS'(window_r);
      default:                prdata = '0;
    endcase
  end

  // sequencing and handshakes
  slpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // averaging, shared divider, lobe tracking, output word
  slpt_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS),
    .THR_BITS    (THR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .accel_z          (in_accel_z),
    .time_ms          (in_time_ms),
    .up_thr           (up_thr_r),
    .down_thr         (down_thr_r),
    .min_gap          (min_gap_r),
    .min_amp          (min_amp_r),
    .window           (window_r),
    .smoothed_z       (out_smoothed_z),
    .step_valid       (out_step_valid),
    .in_up_lobe       (out_in_up_lobe),
    .in_down_lobe     (out_in_down_lobe),
    .segment_start_ms (out_segment_start_ms),
    .segment_started  (out_segment_started)
  );

endmodule

// ----- dv/tb_step_lobe_peak_tracker.sv -----
// testbench for the step lobe peak tracker: directed and random words checked against a predictor
`timescale 1ns / 100ps

module tb_step_lobe_peak_tracker;

  // code the block leaves alone
  localparam logic [slpt_pkg::FUNC_BITS-1:0] FUNC_NONE = 2'd3;

  // accumulator and sample widths at the default parameters
  localparam int SUM_W    = slpt_pkg::SAMPLE_BITS_DEF + 8;
  localparam int SAMPLE_W = slpt_pkg::SAMPLE_BITS_DEF;
  localparam int TIME_W   = slpt_pkg::TIME_BITS_DEF;

  // long receiver hold-off, placed in the middle of a random phase
  localparam int HOLD_AT  = 500;
  localparam int HOLD_LEN = 400;

  // words on the two channels
  typedef struct packed {
    logic [slpt_pkg::FUNC_BITS-1:0] func;
    logic signed [SAMPLE_W-1:0]     accel;
    logic [TIME_W-1:0]              tms;
  } word_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]        smoothed;
    logic                              step;
    logic                              up;
    logic                              down;
    logic [slpt_pkg::SEG_OUT_BITS-1:0] seg_start;
    logic                              seg_started;
  } word_out_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // dut ports
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [slpt_pkg::FUNC_BITS-1:0]       in_func = '0;
  logic signed [SAMPLE_W-1:0]           in_accel_z = '0;
  logic [TIME_W-1:0]                    in_time_ms = '0;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [SAMPLE_W-1:0]           out_smoothed_z;
  logic                                 out_step_valid;
  logic                                 out_in_up_lobe;
  logic                                 out_in_down_lobe;
  logic [slpt_pkg::SEG_OUT_BITS-1:0]    out_segment_start_ms;
  logic                                 out_segment_started;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [slpt_pkg::CFG_ADDR_BITS-1:0]   paddr = '0;
  logic [slpt_pkg::CFG_DATA_BITS-1:0]   pwdata = '0;
  logic [slpt_pkg::CFG_DATA_BITS-1:0]   prdata;
  logic                                 pready;

  step_lobe_peak_tracker u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_accel_z           (in_accel_z),
    .in_time_ms           (in_time_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_smoothed_z       (out_smoothed_z),
    .out_step_valid       (out_step_valid),
    .out_in_up_lobe       (out_in_up_lobe),
    .out_in_down_lobe     (out_in_down_lobe),
    .out_segment_start_ms (out_segment_start_ms),
    .out_segment_started  (out_segment_started),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // register copies, kept in step with every write on the register port
  logic signed [SAMPLE_W-1:0]           cfg_up     = SAMPLE_W'(slpt_pkg::UP_THR_RST);
  logic signed [SAMPLE_W-1:0]           cfg_down   = SAMPLE_W'(slpt_pkg::DOWN_THR_RST);
  logic [slpt_pkg::GAP_BITS-1:0]        cfg_gap    =
    slpt_pkg::GAP_BITS'(slpt_pkg::MIN_GAP_RST);
  logic [slpt_pkg::AMP_BITS-1:0]        cfg_amp    =
    slpt_pkg::AMP_BITS'(slpt_pkg::MIN_AMP_RST);
  logic [slpt_pkg::WIN_CFG_BITS-1:0]    cfg_window =
    slpt_pkg::WIN_CFG_BITS'(slpt_pkg::WINDOW_RST);

  // tracker state as the predictor sees it
  logic signed [SUM_W-1:0]              avg_sum;
  logic [slpt_pkg::WIN_CFG_BITS-1:0]    avg_cnt;
  logic signed [SAMPLE_W-1:0]           smooth_q;
  logic signed [SAMPLE_W-1:0]           peak_hi;
  logic signed [SAMPLE_W-1:0]           peak_lo;
  logic                                 up_lobe_q, down_lobe_q;
  logic                                 up_seen_q, down_seen_q, start_seen_q;
  logic [TIME_W-1:0]                    up_ms, down_ms, start_ms;

  // words waiting to be sent, and tracker words owed by the block
  word_in_t  stim_q[$];
  word_out_t tracker_words_due[$];

  word_in_t    held_word = '0;
  int unsigned gap_left = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic        rx_stall = 1'b0;
  int unsigned rx_wait = 0;
  logic        hold_off = 1'b0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;
  int unsigned words_checked = 0;
  int unsigned n_errors = 0;
  logic [TIME_W-1:0] stamp = '0;

  assign out_stall = rx_stall | hold_off;

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic void clear_segment_state();
    up_lobe_q    = 1'b0;
    down_lobe_q  = 1'b0;
    peak_hi      = 16'sh8000;
    peak_lo      = 16'sh7fff;
    up_ms        = '0;
    up_seen_q    = 1'b0;
    down_ms      = '0;
    down_seen_q  = 1'b0;
    start_ms     = '0;
    start_seen_q = 1'b0;
  endfunction

  function automatic void clear_tracker_state();
    clear_segment_state();
    avg_sum  = '0;
    avg_cnt  = '0;
    smooth_q = '0;
  endfunction

  // advance the tracker by one word and give the word it reports
  function automatic word_out_t track_step(input word_in_t w);
    longint    xv, s, win, div;
    bit        order, amp_ok, gap_ok;
    word_out_t r;
    case (w.func)
      slpt_pkg::FUNC_FEED: begin
        xv  = longint'(w.accel);
        // window of zero acts as one, above the maximum as the maximum
        win = longint'(cfg_window);
        if (win < 1) win = 1;
        if (win > slpt_pkg::MAX_WINDOW_DEF) win = slpt_pkg::MAX_WINDOW_DEF;
        s = longint'(avg_sum);
        if (longint'(avg_cnt) < win) begin
          s = saturate(s + xv, SUM_W);
          avg_cnt = avg_cnt + slpt_pkg::WIN_CFG_BITS'(1);
        end else begin
          // leaky update, also when the window shrank below the count
          s = saturate(s + xv - s / win, SUM_W);
        end
        avg_sum = SUM_W'(s);
        div = (longint'(avg_cnt) < win) ? longint'(avg_cnt) : win;
        if (div < 1) div = 1;
        smooth_q = SAMPLE_W'(saturate(s / div, SAMPLE_W));
        // upward crossing first, a downward one in the same sample wins
        if (!up_lobe_q && smooth_q > cfg_up) begin
          up_lobe_q   = 1'b1;
          down_lobe_q = 1'b0;
          if (smooth_q > peak_hi) peak_hi = smooth_q;
          up_ms     = w.tms;
          up_seen_q = 1'b1;
          if (!start_seen_q) begin
            start_ms     = w.tms;
            start_seen_q = 1'b1;
          end
        end else if (up_lobe_q && smooth_q > peak_hi) begin
          peak_hi = smooth_q;
        end
        if (!down_lobe_q && smooth_q < cfg_down) begin
          down_lobe_q = 1'b1;
          up_lobe_q   = 1'b0;
          if (smooth_q < peak_lo) peak_lo = smooth_q;
          down_ms     = w.tms;
          down_seen_q = 1'b1;
        end else if (down_lobe_q && smooth_q < peak_lo) begin
          peak_lo = smooth_q;
        end
      end
      slpt_pkg::FUNC_CLR_SEG: clear_segment_state();
      slpt_pkg::FUNC_CLR_ALL: clear_tracker_state();
      default: ;
    endcase
    // step needs both crossings in order, enough swing and enough gap
    order  = down_ms >= up_ms;
    amp_ok = (longint'(peak_hi) - longint'(peak_lo)) >= longint'(cfg_amp);
    gap_ok = (down_ms - up_ms) >= TIME_W'(cfg_gap);
    r.smoothed    = smooth_q;
    r.step        = up_seen_q && down_seen_q && order && amp_ok && gap_ok;
    r.up          = up_lobe_q;
    r.down        = down_lobe_q;
    r.seg_start   = start_seen_q ? start_ms : '0;
    r.seg_started = start_seen_q;
    return r;
  endfunction

  // idle cycles before the next word, with runs of back-to-back words
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("mismatch: %s", msg);
  endtask

  // sender: takes words from the queue, predicts each one as it is accepted
  always @(posedge clk) begin
    word_in_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) tracker_words_due.push_back(track_step(held_word));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q.pop_front();
          held_word  <= nxt;
          in_func    <= nxt.func;
          in_accel_z <= nxt.accel;
          in_time_ms <= nxt.tms;
          in_valid   <= 1'b1;
          gap_left   <= draw_wait(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted word against the oldest prediction
  always @(posedge clk) begin
    word_out_t   want;
    int unsigned n;
    if (!rst_n) begin
      rx_stall <= 1'b0;
      rx_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      words_checked <= words_checked + 1;
      if (tracker_words_due.size() == 0) begin
        flag_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = tracker_words_due.pop_front();
        if (out_smoothed_z !== want.smoothed)
          flag_mismatch($sformatf("word %0d smoothed_z %0d, expected %0d", words_checked,
                                  $signed(out_smoothed_z), $signed(want.smoothed)));
        if (out_step_valid !== want.step)
          flag_mismatch($sformatf("word %0d step_valid %b, expected %b", words_checked,
                                  out_step_valid, want.step));
        if (out_in_up_lobe !== want.up)
          flag_mismatch($sformatf("word %0d in_up_lobe %b, expected %b", words_checked,
                                  out_in_up_lobe, want.up));
        if (out_in_down_lobe !== want.down)
          flag_mismatch($sformatf("word %0d in_down_lobe %b, expected %b", words_checked,
                                  out_in_down_lobe, want.down));
        if (out_segment_start_ms !== want.seg_start)
          flag_mismatch($sformatf("word %0d segment_start_ms %0d, expected %0d", words_checked,
                                  out_segment_start_ms, want.seg_start));
        if (out_segment_started !== want.seg_started)
          flag_mismatch($sformatf("word %0d segment_started %b, expected %b", words_checked,
                                  out_segment_started, want.seg_started));
      end
      n = draw_wait(rx_calm);
      rx_wait  <= n;
      rx_stall <= (n != 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) rx_stall <= 1'b0;
    end
  end

  // one long hold-off on the result side so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 1'b0;
    end else if (!hold_done && words_checked >= HOLD_AT) begin
      hold_off  <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  task automatic add_word(input logic [slpt_pkg::FUNC_BITS-1:0] f, input int a,
                          input logic [TIME_W-1:0] t);
    word_in_t w;
    w.func  = f;
    w.accel = SAMPLE_W'(a);
    w.tms   = t;
    stim_q.push_back(w);
  endtask

  // register write: setup cycle, then access until pready
  task automatic write_reg(input logic [slpt_pkg::REG_IDX_BITS-1:0] idx,
                           input logic [slpt_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      slpt_pkg::REG_UP_THR:   cfg_up     = val[SAMPLE_W-1:0];
      slpt_pkg::REG_DOWN_THR: cfg_down   = val[SAMPLE_W-1:0];
      slpt_pkg::REG_MIN_GAP:  cfg_gap    = val[slpt_pkg::GAP_BITS-1:0];
      slpt_pkg::REG_MIN_AMP:  cfg_amp    = val[slpt_pkg::AMP_BITS-1:0];
      slpt_pkg::REG_WINDOW:   cfg_window = val[slpt_pkg::WIN_CFG_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int up, input int down, input int gap, input int amp,
                           input int win);
    write_reg(slpt_pkg::REG_UP_THR, {16'b0, up[15:0]});
    write_reg(slpt_pkg::REG_DOWN_THR, {16'b0, down[15:0]});
    write_reg(slpt_pkg::REG_MIN_GAP, {16'b0, gap[15:0]});
    write_reg(slpt_pkg::REG_MIN_AMP, {16'b0, amp[15:0]});
    write_reg(slpt_pkg::REG_WINDOW, {25'b0, win[6:0]});
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || tracker_words_due.size() != 0) @(posedge clk);
  endtask

  // mostly stride trains (up lobe then down lobe) with random shape,
  // the rest raw noise and lobes cut short by a clear
  task automatic add_random_phase(input int n_words);
    int left, kind, amp, half, dt, reps, r, k, noise;
    logic [slpt_pkg::FUNC_BITS-1:0] f;
    left  = n_words;
    stamp = $urandom();
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        amp  = (kind == 0) ? $urandom_range(12000, 30000) : $urandom_range(50, 12000);
        half = $urandom_range(1, 16);
        dt   = $urandom_range(1, 80);
        reps = $urandom_range(1, 4);
        for (r = 0; r < reps; r++) begin
          for (k = 0; k < 2 * half; k++) begin
            noise = $urandom_range(0, 600);
            stamp = stamp + dt;
            // timestamps stepping back make the down crossing come first
            if (kind == 7 && k == half) stamp = stamp - $urandom_range(0, 4000);
            add_word(slpt_pkg::FUNC_FEED, ((k < half) ? amp : -amp) + noise - 300, stamp);
            left--;
          end
        end
        if (kind == 6) begin
          add_word($urandom_range(0, 1) ? slpt_pkg::FUNC_CLR_SEG : slpt_pkg::FUNC_CLR_ALL,
                   $urandom(), $urandom());
          left--;
        end
      end else if (kind == 8) begin
        f = slpt_pkg::FUNC_BITS'($urandom_range(0, 3));
        add_word(f, $urandom(), $urandom());
        if (f != FUNC_NONE) left--;
      end else begin
        amp  = $urandom_range(500, 20000);
        half = $urandom_range(1, 10);
        for (k = 0; k < half; k++) begin
          stamp = stamp + $urandom_range(1, 50);
          add_word(slpt_pkg::FUNC_FEED, amp, stamp);
          left--;
        end
        add_word($urandom_range(0, 1) ? slpt_pkg::FUNC_CLR_SEG : slpt_pkg::FUNC_CLR_ALL,
                 $urandom(), $urandom());
        left--;
      end
    end
  endtask

  initial begin
    int k;
    clear_tracker_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full-scale samples at reset settings, a valid step first
    add_word(slpt_pkg::FUNC_FEED, 32767, 0);
    add_word(slpt_pkg::FUNC_FEED, 32767, 10);
    add_word(slpt_pkg::FUNC_FEED, -32768, 100);
    add_word(slpt_pkg::FUNC_FEED, -32768, 300);
    add_word(slpt_pkg::FUNC_FEED, -32768, 400);
    // unknown code leaves everything alone
    add_word(FUNC_NONE, 16'sh5a5a, 32'hffff_ffff);
    add_word(slpt_pkg::FUNC_FEED, -32768, 32'hffff_ffff);
    add_word(slpt_pkg::FUNC_CLR_SEG, 0, 0);
    // up crossing just before the timestamp wraps, down after it
    add_word(slpt_pkg::FUNC_FEED, 32767, 32'hffff_fff0);
    add_word(slpt_pkg::FUNC_FEED, 32767, 32'hffff_fffa);
    add_word(slpt_pkg::FUNC_FEED, -32768, 32'h0000_0010);
    add_word(slpt_pkg::FUNC_FEED, -32768, 32'h0000_0020);
    add_word(slpt_pkg::FUNC_CLR_ALL, 16'sha5a5, 32'ha5a5_a5a5);
    // clean stride from a cleared average
    for (k = 0; k < 5; k++) add_word(slpt_pkg::FUNC_FEED, 3000, 1000 + 20 * k);
    for (k = 0; k < 5; k++) add_word(slpt_pkg::FUNC_FEED, -3000, 1300 + 20 * k);
    add_word(slpt_pkg::FUNC_FEED, 0, 1400);
    add_word(slpt_pkg::FUNC_CLR_SEG, 0, 0);
    wait_drained();

    // random phases: settings move between phases with the block idle
    configure(slpt_pkg::UP_THR_RST, slpt_pkg::DOWN_THR_RST, slpt_pkg::MIN_GAP_RST,
              slpt_pkg::MIN_AMP_RST, slpt_pkg::WINDOW_RST);
    add_random_phase(200);
    wait_drained();
    configure(1000, -1000, 100, 3000, 8);
    add_random_phase(200);
    wait_drained();
    // extreme thresholds, widest window
    configure(32767, -32768, 0, 0, 64);
    add_random_phase(200);
    wait_drained();
    // window shrinks under a full count, largest gap and swing limits
    configure(300, -300, 65535, 65535, 1);
    add_random_phase(200);
    wait_drained();
    // thresholds crossed over so one sample opens both lobes; window zero
    configure(-32768, 32767, 50, 100, 0);
    add_random_phase(200);
    wait_drained();
    // crossed thresholds again with a window above the maximum
    configure(-500, 500, 20, 200, 127);
    add_random_phase(200);
    wait_drained();
    configure(128, -128, 300, 1000, 16);
    add_random_phase(200);
    wait_drained();

    // let any stray word show up before the verdict
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
